// ----- src/sle_pkg.sv -----
// sle_pkg: shared types and codes for the sequential list engine
// request/response payload structs, cell command bus, status and request codes
// no dependencies
package sle_pkg;

	// default list capacity
	localparam int CAPACITY_DEF = 64;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ERR      = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	// input item
	typedef struct packed {
		logic        [1:0]  req_type;
		logic        [6:0]  position;
		logic signed [31:0] value;
	} req_t;

	// result item
	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] removed_value;
		logic        [6:0]  found_position;
		logic        [6:0]  list_length;
	} rsp_t;

	// command broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_DELETE = 3'd2,
		CELL_FIND   = 3'd3,
		CELL_SCAN   = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] word;
	} cell_bus_t;

endpackage

// ----- src/sle_cell.sv -----
// sle_cell: one list slot with its entry word and a result carry stage
// shifts entries with its neighbors, compares on find, passes the carry down
// depends on sle_pkg
module sle_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sle_pkg::cell_bus_t   bus,
	input  logic [PW-1:0]        pos_idx,
	input  logic [PW-1:0]        len,
	input  logic [31:0]          left_data,
	input  logic [31:0]          right_data,
	input  logic                 right_hit,
	input  logic [31:0]          right_word,
	input  logic [PW-1:0]        right_pos,
	output logic [31:0]          data,
	output logic                 hit,
	output logic [31:0]          word,
	output logic [PW-1:0]        pos
);
	import sle_pkg::*;

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);
	localparam logic [PW-1:0] MY_POS = PW'(IDX + 1);

	logic [31:0]   data_q;
	logic          hit_q;
	logic [31:0]   word_q;
	logic [PW-1:0] pos_q;

	// entry word: shift up on insert, down on delete
	always_ff @(posedge clk) begin
		case (bus.op)
			CELL_INSERT: begin
				if (MY_IDX == pos_idx) data_q <= bus.word;
				else if (MY_IDX > pos_idx) data_q <= left_data;
			end
			CELL_DELETE: begin
				if (MY_IDX >= pos_idx) data_q <= right_data;
			end
			default: ;
		endcase
	end

	// carry: load on delete or find, then move toward cell zero until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			case (bus.op)
				CELL_DELETE: hit_q <= (MY_IDX == pos_idx);
				CELL_FIND:   hit_q <= (data_q == bus.word) && (MY_IDX < len);
				CELL_SCAN: begin
					if (!hit_q) hit_q <= right_hit;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bus.op)
			CELL_DELETE, CELL_FIND: begin
				word_q <= data_q;
				pos_q  <= MY_POS;
			end
			CELL_SCAN: begin
				if (!hit_q) begin
					word_q <= right_word;
					pos_q  <= right_pos;
				end
			end
			default: ;
		endcase
	end

	assign data = data_q;
	assign hit  = hit_q;
	assign word = word_q;
	assign pos  = pos_q;

endmodule

// ----- src/sequential_list_engine_unit.sv -----
// sequential_list_engine_unit: top level of the sequential list engine
// request decode, length register, scan sequencer and the row of sle_cell slots
// depends on sle_pkg and sle_cell
//
//  channel  | signals           | handshake
//  ---------+-------------------+-------------------------------------------
//  request  | start, busy, req  | item taken at an edge with start high, busy low
//  result   | done, rsp         | done high for one cycle, taken at its end
//
// insert and any failed request: result in the cycle after the request is taken.
// delete and find: busy while the carry moves to cell zero, or for a find without a
// match until the scan counter runs out; the result follows in the next cycle.
// the time is set by the carry chain, which moves one cell per cycle toward cell zero.
// reset empties the list; entry words are not cleared. the receiver cannot stall.
module sequential_list_engine_unit #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sle_pkg::req_t req,
	output logic          done,
	output sle_pkg::rsp_t rsp
);
	import sle_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int CW = ((PW > 7) ? PW : 7) + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [PW-1:0] LAST  = PW'(CAPACITY - 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t        state_q;
	logic [PW-1:0] length_q;
	logic [PW-1:0] cnt_q;
	logic          find_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          accept;
	logic [CW-1:0] pos_ext;
	logic [CW-1:0] len_ext;
	logic [CW-1:0] len_inc;
	logic [CW-1:0] len_dec;
	logic [CW-1:0] lenq_ext;
	logic          ins_ok;
	logic          del_ok;
	logic          find_ok;
	logic [PW-1:0] pos_idx;
	cell_bus_t     bus;
	logic [CW-1:0] hit_pos_ext;

	logic [31:0]   data_w [CAPACITY];
	logic          hit_w  [CAPACITY];
	logic [31:0]   word_w [CAPACITY];
	logic [PW-1:0] pos_w  [CAPACITY];

	assign busy   = (state_q == S_SCAN);
	assign accept = start && !busy;

	// request checks against the current length
	assign pos_ext  = CW'(req.position);
	assign len_ext  = CW'(length_q);
	assign len_inc  = len_ext + CW'(1);
	assign len_dec  = len_ext - CW'(1);
	assign ins_ok   = (req.req_type == REQ_INSERT) && (pos_ext != '0)
	                  && (pos_ext <= len_inc) && (len_ext < CAP_C);
	assign del_ok   = (req.req_type == REQ_DELETE) && (pos_ext != '0)
	                  && (pos_ext <= len_ext);
	assign find_ok  = (req.req_type == REQ_FIND) && (length_q != '0);
	assign pos_idx  = PW'(pos_ext - CW'(1));

	// command to the cell row
	always_comb begin
		bus.word = req.value;
		bus.op   = CELL_HOLD;
		if (accept) begin
			if (ins_ok) bus.op = CELL_INSERT;
			else if (del_ok) bus.op = CELL_DELETE;
			else if (find_ok) bus.op = CELL_FIND;
		end else if (busy) begin
			bus.op = CELL_SCAN;
		end
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0]   left_d;
		logic [31:0]   right_d;
		logic          right_h;
		logic [31:0]   right_wd;
		logic [PW-1:0] right_p;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid
			assign left_d = data_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d  = '0;
			assign right_h  = 1'b0;
			assign right_wd = '0;
			assign right_p  = '0;
		end else begin : g_inner
			assign right_d  = data_w[i+1];
			assign right_h  = hit_w[i+1];
			assign right_wd = word_w[i+1];
			assign right_p  = pos_w[i+1];
		end

		sle_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.bus        (bus),
			.pos_idx    (pos_idx),
			.len        (length_q),
			.left_data  (left_d),
			.right_data (right_d),
			.right_hit  (right_h),
			.right_word (right_wd),
			.right_pos  (right_p),
			.data       (data_w[i]),
			.hit        (hit_w[i]),
			.word       (word_w[i]),
			.pos        (pos_w[i])
		);
	end

	assign lenq_ext    = CW'(length_q);
	assign hit_pos_ext = CW'(pos_w[0]);

	// sequencer, length register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			length_q <= '0;
			cnt_q    <= '0;
			find_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (del_ok || find_ok) begin
							state_q <= S_SCAN;
							cnt_q   <= LAST;
							find_q  <= find_ok;
							if (del_ok) length_q <= PW'(len_dec);
						end else begin
							done_q <= 1'b1;
							if (ins_ok) length_q <= PW'(len_inc);
						end
					end
				end
				S_SCAN: begin
					if (hit_w[0] || (cnt_q == '0)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - PW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && !(del_ok || find_ok)) begin
			rsp_q.status         <= ins_ok ? ST_OK : ST_ERR;
			rsp_q.removed_value  <= '0;
			rsp_q.found_position <= '0;
			rsp_q.list_length    <= ins_ok ? len_inc[6:0] : len_ext[6:0];
		end else if (busy && (hit_w[0] || (cnt_q == '0))) begin
			rsp_q.list_length <= lenq_ext[6:0];
			if (find_q) begin
				rsp_q.status         <= hit_w[0] ? ST_OK : ST_NOTFOUND;
				rsp_q.removed_value  <= '0;
				rsp_q.found_position <= hit_w[0] ? hit_pos_ext[6:0] : 7'd0;
			end else begin
				rsp_q.status         <= ST_OK;
				rsp_q.removed_value  <= word_w[0];
				rsp_q.found_position <= '0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
